// File: rtl/sjfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfq_pkg: shared types and constants
// Transaction payloads, status codes, queue entry layout and the reset values
// of the per-kind minutes registers.
// ----------------------------------------------------------------------------
package sjfq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int NUM_KINDS   = 8;

	localparam int KIND_W   = 3;
	localparam int AMOUNT_W = 8;
	localparam int MIN_W    = 10;
	localparam int KEY_W    = 18;
	localparam int CFG_IDX_W = 4;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic [MIN_W-1:0] MINUTES_RESET [NUM_KINDS] = '{
		10'd45, 10'd90, 10'd105, 10'd45, 10'd105, 10'd85, 10'd45, 10'd10
	};

	typedef struct packed {
		logic                operation;
		logic [KIND_W-1:0]   item_kind;
		logic [AMOUNT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [KIND_W-1:0]   out_kind;
		logic [AMOUNT_W-1:0] out_amount;
		logic [KEY_W-1:0]    out_key;
	} rsp_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [AMOUNT_W-1:0] amount;
		logic [KEY_W-1:0]    key;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic    capture;      // latch request, compute key
		logic    ld_ins;       // init insertion pointers at the tail
		logic    step;         // move insertion pointers one slot toward head
		logic    rd_head;      // read head entry
		logic    rd_ptr;       // read entry just ahead of the write slot
		logic    wr_shift;     // move read entry one slot back
		logic    wr_new;       // write the new entry at the write slot
		logic    enq_commit;
		logic    deq_commit;
		logic    out_load;
		status_t out_status;
		logic    out_with_data;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_deq;
		logic full;
		logic empty;
		logic j_zero;
		logic greater;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/sjfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module sjfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/sjfq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfq_dp: queue datapath
// Config registers, key multiply, circular sorted store with head/tail
// pointers, insertion pointers and the result register.
// ----------------------------------------------------------------------------
module sjfq_dp #(
	parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sjfq_pkg::req_t                 req,
	input  logic                           cfg_wen,
	input  logic [sjfq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sjfq_pkg::MIN_W-1:0]     cfg_wdata,
	input  sjfq_pkg::cmd_t                 cmd,
	output sjfq_pkg::sts_t                 sts,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output sjfq_pkg::rsp_t                 rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam int KEY_W = sjfq_pkg::KEY_W;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		ptr_dec = (p == '0) ? LAST : p - 1'b1;
	endfunction

	logic [sjfq_pkg::MIN_W-1:0] minutes_q [sjfq_pkg::NUM_KINDS];

	logic                          op_q;
	logic [sjfq_pkg::KIND_W-1:0]   kind_q;
	logic [sjfq_pkg::AMOUNT_W-1:0] amount_q;
	logic [KEY_W-1:0]              key_q;
	logic [KEY_W-1:0]              prod;

	logic [AW-1:0] head_q, tail_q, wptr_q, rptr_q;
	logic [CW-1:0] count_q, jcnt_q;

	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_raddr;
	sjfq_pkg::entry_t        ram_wdata, ram_rdata, new_entry;

	logic                    rsp_valid_q;
	sjfq_pkg::rsp_t          rsp_q;
	logic                    take;

	// ---- config ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < sjfq_pkg::NUM_KINDS; k++) begin
				minutes_q[k] <= sjfq_pkg::MINUTES_RESET[k];
			end
		end else if (cfg_wen && (cfg_index < sjfq_pkg::CFG_IDX_W'(sjfq_pkg::NUM_KINDS))) begin
			minutes_q[cfg_index[sjfq_pkg::KIND_W-1:0]] <= cfg_wdata;
		end
	end

	// ---- request capture, key is fixed at enqueue time ----
	assign prod = KEY_W'(minutes_q[req.item_kind]) * KEY_W'(req.amount);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req.operation;
			kind_q   <= req.item_kind;
			amount_q <= req.amount;
			key_q    <= prod;
		end
	end

	assign new_entry = '{kind: kind_q, amount: amount_q, key: key_q};

	// ---- pointers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			wptr_q  <= '0;
			rptr_q  <= '0;
			jcnt_q  <= '0;
		end else begin
			if (cmd.ld_ins) begin
				wptr_q <= tail_q;
				rptr_q <= ptr_dec(tail_q);
				jcnt_q <= count_q;
			end else if (cmd.step) begin
				wptr_q <= rptr_q;
				rptr_q <= ptr_dec(rptr_q);
				jcnt_q <= jcnt_q - 1'b1;
			end
			if (cmd.enq_commit) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + 1'b1;
			end else if (cmd.deq_commit) begin
				head_q  <= ptr_inc(head_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	// ---- entry store ----
	assign ram_we    = cmd.wr_shift | cmd.wr_new;
	assign ram_wdata = cmd.wr_shift ? ram_rdata : new_entry;
	assign ram_re    = cmd.rd_head | cmd.rd_ptr;
	assign ram_raddr = cmd.rd_head ? head_q : rptr_q;

	sjfq_ram #(
		.WIDTH($bits(sjfq_pkg::entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wptr_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---- result register ----
	assign take = rsp_valid_q && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status <= cmd.out_status;
			if (cmd.out_with_data) begin
				rsp_q.out_kind   <= ram_rdata.kind;
				rsp_q.out_amount <= ram_rdata.amount;
				rsp_q.out_key    <= ram_rdata.key;
			end else begin
				rsp_q.out_kind   <= '0;
				rsp_q.out_amount <= '0;
				rsp_q.out_key    <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---- status ----
	assign sts.op_deq   = (op_q == sjfq_pkg::OP_DEQ);
	assign sts.full     = (count_q == FULL_CNT);
	assign sts.empty    = (count_q == '0);
	assign sts.j_zero   = (jcnt_q == '0);
	assign sts.greater  = (ram_rdata.key > key_q);
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	// ---- checks ----
	logic [CW:0] ptr_sum, ptr_wrap;
	assign ptr_sum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign ptr_wrap = (ptr_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
		ptr_sum - (CW + 1)'(QUEUE_DEPTH) : ptr_sum;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_no_enq_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_commit |-> !sts.full)
		else $error("enqueue committed on full queue");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_wrap == (CW + 1)'(tail_q))
		else $error("tail does not match head plus count");

endmodule

// File: rtl/sjfq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjfq_ctrl: queue controller
// Sequences one transaction at a time: decode, insertion walk or head pop,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module sjfq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output sjfq_pkg::cmd_t cmd,
	input  sjfq_pkg::sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DECODE   = 6'b000010,
		S_INS_CHK  = 6'b000100,
		S_INS_CMP  = 6'b001000,
		S_DEQ_DATA = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	sjfq_pkg::status_t resp_status_q, resp_status_d;
	logic              resp_data_q, resp_data_d;
	logic              accept;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d       = state_q;
		resp_status_d = resp_status_q;
		resp_data_d   = resp_data_q;
		cmd           = '0;
		cmd.out_status    = resp_status_q;
		cmd.out_with_data = resp_data_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				resp_status_d = sjfq_pkg::ST_DONE;
				resp_data_d   = 1'b0;
				if (sts.op_deq) begin
					if (sts.empty) begin
						resp_status_d = sjfq_pkg::ST_EMPTY;
						state_d       = S_RESP;
					end else begin
						cmd.rd_head = 1'b1;
						state_d     = S_DEQ_DATA;
					end
				end else begin
					if (sts.full) begin
						resp_status_d = sjfq_pkg::ST_FULL;
						state_d       = S_RESP;
					end else begin
						cmd.ld_ins = 1'b1;
						state_d    = S_INS_CHK;
					end
				end
			end
			S_INS_CHK: begin
				if (sts.j_zero) begin
					cmd.wr_new     = 1'b1;
					cmd.enq_commit = 1'b1;
					state_d        = S_RESP;
				end else begin
					cmd.rd_ptr = 1'b1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				// strictly greater moves back; equal keys stay ahead (FIFO)
				if (sts.greater) begin
					cmd.wr_shift = 1'b1;
					cmd.step     = 1'b1;
					state_d      = S_INS_CHK;
				end else begin
					cmd.wr_new     = 1'b1;
					cmd.enq_commit = 1'b1;
					state_d        = S_RESP;
				end
			end
			S_DEQ_DATA: begin
				cmd.deq_commit = 1'b1;
				resp_data_d    = 1'b1;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			resp_status_q <= sjfq_pkg::ST_DONE;
			resp_data_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			resp_status_q <= resp_status_d;
			resp_data_q   <= resp_data_d;
		end
	end

	a_decode_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DECODE)
		else $error("accepted transaction not decoded next cycle");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> $past(cmd.rd_ptr))
		else $error("compare without a preceding read");

	a_deq_after_head_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEQ_DATA |-> $past(cmd.rd_head))
		else $error("dequeue data without a head read");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_new |-> !cmd.wr_shift && $past(state_q != S_IDLE))
		else $error("conflicting store writes");

endmodule

// File: rtl/shortest_job_first_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_job_first_queue_top: bounded shortest-job-first queue
// Stable sorted priority queue keyed by per-kind minutes times amount.
// ----------------------------------------------------------------------------
// One transaction is in work at a time; req_stall is high from the cycle after
// acceptance until the result is handed to the output register, which frees
// the request side while the result waits on rsp_stall. An enqueue walks back
// from the tail through the entry RAM, one read and one compare per step,
// moving each stored entry with a key strictly greater than the new key one
// slot back, and stops at the head or on an entry with a smaller or equal key.
// A dequeue reads the head entry; a full-queue enqueue and an empty-queue
// dequeue go straight to the result. A result still waiting on rsp_stall holds
// the next transaction at its hand-off until it is taken. Entries sit in a
// circular buffer so a pop only advances the head pointer. The key is computed
// once at enqueue with the current minutes register; later config writes do
// not reorder the queue. Equal keys leave in arrival order. Config writes with
// an index of 8 or more are ignored. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module shortest_job_first_queue_top #(
	parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request transactions
	input  logic                           req_valid,
	output logic                           req_stall,
	input  sjfq_pkg::req_t                 req,
	// result transactions
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output sjfq_pkg::rsp_t                 rsp,
	// config write port
	input  logic                           cfg_wen,
	input  logic [sjfq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sjfq_pkg::MIN_W-1:0]     cfg_wdata
);

	sjfq_pkg::cmd_t cmd;
	sjfq_pkg::sts_t sts;

	// sequencing
	sjfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// storage, key math and result register
	sjfq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
